[design/pci_pkg.sv]
// Shared types and constants of the pilot channel interpolator.
`default_nettype none
package pci_pkg;

  localparam int VALUE_BITS   = 16;
  localparam int NUM_CARRIERS = 32;
  localparam int IDX_W        = $clog2(NUM_CARRIERS);
  localparam int MID_CARRIER  = NUM_CARRIERS / 2;
  // signed segment length / start: spans -NUM_CARRIERS .. 2*NUM_CARRIERS-1
  localparam int LEN_W        = IDX_W + 2;

  localparam int DIV_NUM_W    = VALUE_BITS + 2;
  localparam int DIV_DEN_W    = LEN_W;
  localparam int DIV_CNT_W    = $clog2(DIV_NUM_W);

  localparam int NUM_POS_REGS = 6;
  localparam int POS_SEL_W    = $clog2(NUM_POS_REGS);
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = IDX_W;

  localparam logic [CFG_IDX_W-1:0] CFG_VALUE_MODE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_POS_A      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_POS_F      = 3'd6;

  localparam logic [IDX_W-1:0] POS_RESET [NUM_POS_REGS] = '{
    5'd2, 5'd7, 5'd12, 5'd19, 5'd24, 5'd29
  };

  typedef struct packed {
    logic                  start;
    logic [VALUE_BITS-1:0] mag;
    logic [LEN_W-2:0]      len;
  } div_req_t;

  typedef struct packed {
    logic                  done;
    logic [VALUE_BITS-1:0] quot;
  } div_rsp_t;

endpackage
`default_nettype wire

[design/pci_ram.sv]
// Generic single-port-write, registered-read RAM.
`default_nettype none
module pci_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

[design/pci_div.sv]
// Bit-serial rounding divider: quot = (2*mag + len) / (2*len), one bit per cycle.
`default_nettype none
module pci_div (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire pci_pkg::div_req_t req,
  output pci_pkg::div_rsp_t      rsp
);
  import pci_pkg::*;

  logic [DIV_NUM_W-1:0] num_sr;
  logic [DIV_DEN_W-1:0] rem;
  logic [DIV_DEN_W-1:0] den;
  logic [DIV_CNT_W-1:0] cnt;
  logic                 busy;
  logic                 done;

  logic [DIV_DEN_W:0]   trial;
  logic                 ge;

  assign trial = {rem, num_sr[DIV_NUM_W-1]};
  assign ge    = (trial >= {1'b0, den});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        num_sr <= DIV_NUM_W'({req.mag, 1'b0}) + DIV_NUM_W'(req.len);
        den    <= {req.len, 1'b0};
        rem    <= '0;
        cnt    <= '0;
        busy   <= 1'b1;
      end else if (busy) begin
        rem    <= ge ? DIV_DEN_W'(trial - {1'b0, den}) : DIV_DEN_W'(trial);
        num_sr <= {num_sr[DIV_NUM_W-2:0], ge};
        if (cnt == DIV_CNT_W'(DIV_NUM_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt + 1'b1;
        end
      end
    end
  end

  // quotient never exceeds mag, so the low bits hold it
  assign rsp.done = done;
  assign rsp.quot = num_sr[VALUE_BITS-1:0];

endmodule
`default_nettype wire

[design/pilot_channel_interpolator_core.sv]
// Top level of the OFDM pilot channel interpolator.
//
// Usage: pilot estimates of one symbol enter on the in channel (in_valid /
// in_stall, pilot_value), NUM_PILOTS beats per symbol in pilot order. After
// the last pilot the block builds a line of 32 carrier values in a RAM and
// then sends 32 beats on the out channel (carrier_index 0..31, carrier_value,
// last_carrier on carrier 31). in_stall is high from the last pilot until
// the last carrier has been loaded into the output register.
// Build: after the last pilot the build runs one shared sequencer: a
// segment passes S_SEG and S_LOAD, then, if its length L is positive, the
// bit-serial divider (S_DIV) and L carrier writes in S_FILL; each hold fill
// writes one carrier a cycle. Readout takes each carrier through a
// registered RAM read, then an output load, and waits while the receiver
// stalls.
// Configuration (cfg_valid / cfg_ready, cfg_index, cfg_data) is ready only
// while the block is idle, so a build always sees stable settings.
// Reset: clears the pilot count, the mode and the pilot positions to their
// defaults, the output valid and the sequencer. A stalled output beat holds.
`default_nettype none
module pilot_channel_interpolator_core #(
  parameter int NUM_PILOTS = 6
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire logic [pci_pkg::VALUE_BITS-1:0]   pilot_value,
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output logic      [pci_pkg::IDX_W-1:0]        carrier_index,
  output logic      [pci_pkg::VALUE_BITS-1:0]   carrier_value,
  output logic                                  last_carrier,
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [pci_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [pci_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import pci_pkg::*;

  localparam int SEL_W = (NUM_PILOTS > 1) ? $clog2(NUM_PILOTS) : 1;
  localparam int SEG_W = $clog2(NUM_PILOTS + 1);
  localparam int STEP_W = VALUE_BITS + 2;
  localparam int ACC_W  = VALUE_BITS + LEN_W + 1;

  typedef enum logic [8:0] {
    S_IDLE    = 9'b000000001,
    S_SEG     = 9'b000000010,
    S_LOAD    = 9'b000000100,
    S_DIV     = 9'b000001000,
    S_FILL    = 9'b000010000,
    S_LHOLD   = 9'b000100000,
    S_UHOLD   = 9'b001000000,
    S_EMIT_RD = 9'b010000000,
    S_EMIT_LD = 9'b100000000
  } state_t;

  state_t state;

  // configuration
  logic             value_mode;
  logic [IDX_W-1:0] pos_reg [NUM_POS_REGS];

  logic [VALUE_BITS-1:0] pilot_store [NUM_PILOTS];
  logic [SEL_W-1:0]      pilot_count;

  // sequencer / datapath
  logic [SEG_W-1:0]         seg;
  logic                     hold_done;
  logic signed [LEN_W-1:0]  seg_start;
  logic [LEN_W-2:0]         seg_len;
  logic [LEN_W-2:0]         k;
  logic [VALUE_BITS-1:0]    v0;
  logic                     d_neg;
  logic signed [STEP_W-1:0] step;
  logic signed [ACC_W-1:0]  acc;
  logic [IDX_W-1:0]         wr_idx;
  logic [IDX_W-1:0]         hold_idx;
  logic [IDX_W-1:0]         hold_end;
  logic [VALUE_BITS-1:0]    hold_val;
  logic [IDX_W-1:0]         emit_idx;
  logic [NUM_CARRIERS-1:0]  line_vld;

  logic [SEG_W-1:0]         low;
  logic [SEL_W-1:0]         rd_sel;
  logic [VALUE_BITS-1:0]    store_rd;
  logic [IDX_W-1:0]         pos_rd;
  logic signed [LEN_W-1:0]  len_c;
  logic signed [VALUE_BITS:0] diff_c;
  logic signed [VALUE_BITS:0] d_c;
  logic [VALUE_BITS:0]      mag_c;
  logic [VALUE_BITS-1:0]    fill_val;
  logic [STEP_W-1:0]        quot_x;

  logic                     ram_we;
  logic [IDX_W-1:0]         ram_waddr;
  logic [VALUE_BITS-1:0]    ram_wdata;
  logic [VALUE_BITS-1:0]    ram_rdata;

  div_req_t div_req;
  div_rsp_t div_rsp;

  assign in_stall  = (state != S_IDLE);
  assign cfg_ready = (state == S_IDLE);

  // first pilot at or above the middle carrier; NUM_PILOTS if none
  always_comb begin
    low = SEG_W'(NUM_PILOTS);
    for (int i = NUM_PILOTS - 1; i >= 0; i--) begin
      if (pos_reg[i] >= IDX_W'(MID_CARRIER)) begin
        low = SEG_W'(i);
      end
    end
  end

  // single read mux into the pilot store and position registers
  always_comb begin
    rd_sel = '0;
    unique case (state)
      S_SEG: begin
        if (seg == low && !hold_done) begin
          rd_sel = (low != '0) ? SEL_W'(low - 1'b1) : SEL_W'(low);
        end else begin
          rd_sel = (seg == '0) ? SEL_W'(NUM_PILOTS - 1) : SEL_W'(seg - 1'b1);
        end
      end
      S_LOAD:  rd_sel = SEL_W'(seg);
      S_LHOLD: rd_sel = (low < SEG_W'(NUM_PILOTS)) ? SEL_W'(low) : '0;
      default: rd_sel = '0;
    endcase
  end

  assign store_rd = pilot_store[rd_sel];
  assign pos_rd   = pos_reg[rd_sel];

  assign len_c  = $signed({2'b00, pos_rd}) - seg_start;
  assign diff_c = $signed({1'b0, store_rd}) - $signed({1'b0, v0});
  // phase differences wrap to the principal range
  assign d_c    = value_mode ? {diff_c[VALUE_BITS-1], diff_c[VALUE_BITS-1:0]} : diff_c;
  assign mag_c  = d_c[VALUE_BITS] ? (VALUE_BITS + 1)'(-d_c) : d_c;

  assign div_req.start = (state == S_LOAD) && !len_c[LEN_W-1] && (len_c != '0);
  assign div_req.mag   = mag_c[VALUE_BITS-1:0];
  assign div_req.len   = len_c[LEN_W-2:0];

  assign quot_x = {2'b00, div_rsp.quot};

  // amplitude saturates, phase wraps
  always_comb begin
    if (value_mode) begin
      fill_val = acc[VALUE_BITS-1:0];
    end else if (acc[ACC_W-1]) begin
      fill_val = '0;
    end else if (|acc[ACC_W-2:VALUE_BITS]) begin
      fill_val = '1;
    end else begin
      fill_val = acc[VALUE_BITS-1:0];
    end
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = hold_idx;
    ram_wdata = hold_val;
    unique case (state)
      S_FILL: begin
        ram_we    = 1'b1;
        ram_waddr = wr_idx;
        ram_wdata = fill_val;
      end
      S_LHOLD, S_UHOLD: ram_we = 1'b1;
      default: ram_we = 1'b0;
    endcase
  end

  pci_ram #(
    .WIDTH(VALUE_BITS),
    .DEPTH(NUM_CARRIERS)
  ) u_line_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(emit_idx),
    .rdata(ram_rdata)
  );

  pci_div u_div (
    .clk(clk),
    .rst(rst),
    .req(div_req),
    .rsp(div_rsp)
  );

  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_valid) begin
      pilot_store[pilot_count] <= pilot_value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      value_mode <= 1'b0;
      pos_reg    <= POS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == CFG_VALUE_MODE) begin
        value_mode <= cfg_data[0];
      end else if (cfg_index >= CFG_POS_A && cfg_index <= CFG_POS_F) begin
        pos_reg[POS_SEL_W'(cfg_index - CFG_POS_A)] <= cfg_data;
      end
    end
  end

  // datapath registers, no reset needed
  always_ff @(posedge clk) begin
    unique case (state)
      S_SEG: begin
        if (seg == low && !hold_done) begin
          hold_val <= store_rd;
          if (low != '0) begin
            hold_idx <= pos_rd;
          end else begin
            hold_idx <= IDX_W'(MID_CARRIER);
            hold_end <= pos_rd;
          end
        end else begin
          v0        <= store_rd;
          seg_start <= (seg == '0) ? $signed({2'b00, pos_rd}) - LEN_W'(NUM_CARRIERS)
                                   : $signed({2'b00, pos_rd});
        end
      end
      S_LOAD: begin
        seg_len <= len_c[LEN_W-2:0];
        d_neg   <= d_c[VALUE_BITS];
      end
      S_DIV: begin
        step   <= d_neg ? $signed(-quot_x) : $signed(quot_x);
        acc    <= ACC_W'({1'b0, v0});
        k      <= '0;
        wr_idx <= seg_start[IDX_W-1:0];
      end
      S_FILL: begin
        acc    <= acc + ACC_W'(step);
        wr_idx <= wr_idx + 1'b1;
        k      <= k + 1'b1;
      end
      S_LHOLD: begin
        if (hold_idx == IDX_W'(MID_CARRIER - 1)) begin
          hold_idx <= IDX_W'(MID_CARRIER);
          hold_end <= pos_rd;
          hold_val <= store_rd;
        end else begin
          hold_idx <= hold_idx + 1'b1;
        end
      end
      S_UHOLD: hold_idx <= hold_idx + 1'b1;
      default: ;
    endcase
    if (state == S_EMIT_LD && (!out_valid || !out_stall)) begin
      carrier_index <= emit_idx;
      carrier_value <= line_vld[emit_idx] ? ram_rdata : '0;
      last_carrier  <= (emit_idx == IDX_W'(NUM_CARRIERS - 1));
    end
  end

  // sequencer and control
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      pilot_count <= '0;
      seg         <= '0;
      hold_done   <= 1'b0;
      emit_idx    <= '0;
      line_vld    <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (out_valid && !out_stall && state != S_EMIT_LD) begin
        out_valid <= 1'b0;
      end
      if (ram_we) begin
        line_vld[ram_waddr] <= 1'b1;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            if (pilot_count == SEL_W'(NUM_PILOTS - 1)) begin
              pilot_count <= '0;
              line_vld    <= '0;
              seg         <= '0;
              hold_done   <= 1'b0;
              state       <= S_SEG;
            end else begin
              pilot_count <= pilot_count + 1'b1;
            end
          end
        end
        S_SEG: begin
          if (seg == low && !hold_done) begin
            state <= (low != '0) ? S_LHOLD : S_UHOLD;
          end else if (seg == SEG_W'(NUM_PILOTS)) begin
            emit_idx <= '0;
            state    <= S_EMIT_RD;
          end else if (seg == low) begin
            // segment across the middle is covered by the hold fills
            seg <= seg + 1'b1;
          end else begin
            state <= S_LOAD;
          end
        end
        S_LOAD: begin
          if (div_req.start) begin
            state <= S_DIV;
          end else begin
            seg   <= seg + 1'b1;
            state <= S_SEG;
          end
        end
        S_DIV: begin
          if (div_rsp.done) begin
            state <= S_FILL;
          end
        end
        S_FILL: begin
          if (k == seg_len - 1'b1) begin
            seg   <= seg + 1'b1;
            state <= S_SEG;
          end
        end
        S_LHOLD: begin
          if (hold_idx == IDX_W'(MID_CARRIER - 1)) begin
            if (low < SEG_W'(NUM_PILOTS)) begin
              state <= S_UHOLD;
            end else begin
              hold_done <= 1'b1;
              state     <= S_SEG;
            end
          end
        end
        S_UHOLD: begin
          if (hold_idx == hold_end) begin
            hold_done <= 1'b1;
            state     <= S_SEG;
          end
        end
        S_EMIT_RD: state <= S_EMIT_LD;
        S_EMIT_LD: begin
          if (!out_valid || !out_stall) begin
            out_valid <= 1'b1;
            if (emit_idx == IDX_W'(NUM_CARRIERS - 1)) begin
              state <= S_IDLE;
            end else begin
              emit_idx <= emit_idx + 1'b1;
              state    <= S_EMIT_RD;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire
